// ===== rtl/jss_pkg.sv =====
package jss_pkg;

	localparam logic [8:0] OP_ADJSP = 9'o105;
	localparam logic [8:0] OP_AOBJP = 9'o252;
	localparam logic [8:0] OP_AOBJN = 9'o253;
	localparam logic [8:0] OP_JFCL  = 9'o255;
	localparam logic [8:0] OP_PUSH  = 9'o261;
	localparam logic [8:0] OP_POP   = 9'o262;
	localparam logic [8:0] OP_POPJ  = 9'o263;
	localparam logic [8:0] OP_JUMP  = 9'o320;
	localparam logic [8:0] OP_SKIP  = 9'o330;

	localparam int          FLAG_TR2    = 3;
	localparam int          JFCL_SHIFT  = 9;
	localparam logic [11:0] LOCAL_MASK  = 12'o7777;

	typedef enum logic [3:0] {
		CLS_NONE,
		CLS_JUMP,
		CLS_SKIP,
		CLS_AOBJP,
		CLS_AOBJN,
		CLS_JFCL,
		CLS_PUSH,
		CLS_POP,
		CLS_POPJ,
		CLS_ADJSP
	} cls_t;

	typedef struct packed {
		logic [8:0]  action;
		logic [3:0]  ac_field;
		logic [35:0] ac_value;
		logic [35:0] operand_word;
		logic [35:0] stack_word;
		logic [22:0] effective_address;
		logic        in_section_zero;
		logic [12:0] flags_in;
	} in_item_t;

	typedef struct packed {
		logic        take_jump;
		logic        take_skip;
		logic        take_trap;
		logic        ac_write;
		logic [35:0] ac_result;
		logic        mem_write;
		logic [22:0] mem_address;
		logic [35:0] mem_data;
		logic [17:0] jump_target;
		logic [12:0] flags_out;
	} out_item_t;

	typedef struct packed {
		cls_t        cls;
		logic        cond_hit;
		logic        local_ptr;
		logic [17:0] step;
		logic [3:0]  ac_field;
		logic [35:0] ac_value;
		logic [35:0] operand_word;
		logic [35:0] stack_word;
		logic [22:0] effective_address;
		logic [12:0] flags_in;
	} dec_t;

	typedef struct packed {
		cls_t        cls;
		logic        cond_hit;
		logic        local_ptr;
		logic        prev_neg;
		logic        step_neg;
		logic        step_nz;
		logic [35:0] stepped;
		logic [3:0]  ac_field;
		logic [35:0] ac_value;
		logic [35:0] operand_word;
		logic [35:0] stack_word;
		logic [22:0] effective_address;
		logic [12:0] flags_in;
	} stp_t;

endpackage

// ===== rtl/jss_req_if.sv =====
interface jss_req_if import jss_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/jss_rsp_if.sv =====
interface jss_rsp_if import jss_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/jump_skip_stack_execute_unit.sv =====
// Executes one jump, skip or stack instruction per transaction (jump/skip
// group, AOBJP/AOBJN, JFCL, PUSH, POP, POPJ, ADJSP) and returns one result
// transaction each. A new transaction is taken every cycle unless a result
// stall backs up to the input; it passes the decode, pointer-step and resolve
// register stages, the pointer step stage holding the 36-bit add. The last
// stage is the output register, and a stall on the result side backs up stage
// by stage, so empty stages keep filling while a result waits.
module jump_skip_stack_execute_unit import jss_pkg::*; #(
	parameter int GLOBAL_ADDRESS_BITS = 23
) (
	input  logic      clk,
	input  logic      arst_n,
	jss_req_if.sink   req,
	jss_rsp_if.source rsp
);

	logic valid_s1;
	dec_t data_s1;
	logic ready_s1;
	logic valid_s2;
	stp_t data_s2;
	logic ready_s2;

	jss_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_data    (req.payload),
		.in_ready   (req.ready),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.next_ready (ready_s1)
	);

	jss_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.ready_s1   (ready_s1),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.next_ready (ready_s2)
	);

	jss_resolve #(
		.GLOBAL_ADDRESS_BITS (GLOBAL_ADDRESS_BITS)
	) u_resolve (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.ready_s2   (ready_s2),
		.valid_s3   (rsp.valid),
		.data_s3    (rsp.payload),
		.next_ready (rsp.ready)
	);

endmodule

// ===== rtl/jss_decode.sv =====
module jss_decode import jss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	output logic     in_ready,
	output logic     valid_s1,
	output dec_t     data_s1,
	input  logic     next_ready
);

	cls_t        cls;
	logic        neg;
	logic        zero;
	logic        cond_hit;
	logic        local_ptr;
	logic [17:0] step;
	logic [35:0] test_val;
	logic [17:0] lh;
	logic        adv;

	assign adv      = !valid_s1 || next_ready;
	assign in_ready = adv;

	always_comb begin
		priority if (in_data.action[8:3] == OP_JUMP[8:3]) begin
			cls = CLS_JUMP;
		end else if (in_data.action[8:3] == OP_SKIP[8:3]) begin
			cls = CLS_SKIP;
		end else if (in_data.action == OP_AOBJP) begin
			cls = CLS_AOBJP;
		end else if (in_data.action == OP_AOBJN) begin
			cls = CLS_AOBJN;
		end else if (in_data.action == OP_JFCL) begin
			cls = CLS_JFCL;
		end else if (in_data.action == OP_PUSH) begin
			cls = CLS_PUSH;
		end else if (in_data.action == OP_POP) begin
			cls = CLS_POP;
		end else if (in_data.action == OP_POPJ) begin
			cls = CLS_POPJ;
		end else if (in_data.action == OP_ADJSP) begin
			cls = CLS_ADJSP;
		end else begin
			cls = CLS_NONE;
		end
	end

	// condition test on the ac for jumps, on the memory word for skips
	assign test_val = (cls == CLS_SKIP) ? in_data.operand_word : in_data.ac_value;
	assign neg      = test_val[35];
	assign zero     = (test_val == 36'd0);

	always_comb begin
		unique case (in_data.action[2:0])
			3'd0:    cond_hit = 1'b0;
			3'd1:    cond_hit = neg;
			3'd2:    cond_hit = zero;
			3'd3:    cond_hit = neg || zero;
			3'd4:    cond_hit = 1'b1;
			3'd5:    cond_hit = !neg;
			3'd6:    cond_hit = !zero;
			default: cond_hit = !neg && !zero;
		endcase
	end

	assign lh = in_data.ac_value[35:18];

	always_comb begin
		local_ptr = in_data.in_section_zero || lh[17] || ((lh[11:0] & LOCAL_MASK) == 12'd0);
		step      = 18'd0;
		unique case (cls)
			CLS_AOBJP, CLS_AOBJN: begin
				local_ptr = 1'b1;
				step      = 18'd1;
			end
			CLS_PUSH:           step = 18'd1;
			CLS_POP, CLS_POPJ:  step = '1;
			CLS_ADJSP:          step = in_data.effective_address[17:0];
			default:            step = 18'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_s1.cls               <= cls;
			data_s1.cond_hit          <= cond_hit;
			data_s1.local_ptr         <= local_ptr;
			data_s1.step              <= step;
			data_s1.ac_field          <= in_data.ac_field;
			data_s1.ac_value          <= in_data.ac_value;
			data_s1.operand_word      <= in_data.operand_word;
			data_s1.stack_word        <= in_data.stack_word;
			data_s1.effective_address <= in_data.effective_address;
			data_s1.flags_in          <= in_data.flags_in;
		end
	end

endmodule

// ===== rtl/jss_step.sv =====
module jss_step import jss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  dec_t data_s1,
	output logic ready_s1,
	output logic valid_s2,
	output stp_t data_s2,
	input  logic next_ready
);

	logic [17:0] lh_new;
	logic [17:0] rh_new;
	logic [35:0] glob_new;
	logic        adv;

	assign adv      = !valid_s2 || next_ready;
	assign ready_s1 = adv;

	// local pointers step each half, global pointers the whole word
	assign lh_new   = data_s1.ac_value[35:18] + data_s1.step;
	assign rh_new   = data_s1.ac_value[17:0] + data_s1.step;
	assign glob_new = data_s1.ac_value + {{18{data_s1.step[17]}}, data_s1.step};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			data_s2.cls               <= data_s1.cls;
			data_s2.cond_hit          <= data_s1.cond_hit;
			data_s2.local_ptr         <= data_s1.local_ptr;
			data_s2.prev_neg          <= data_s1.ac_value[35];
			data_s2.step_neg          <= data_s1.step[17];
			data_s2.step_nz           <= (data_s1.step != 18'd0);
			data_s2.stepped           <= data_s1.local_ptr ? {lh_new, rh_new} : glob_new;
			data_s2.ac_field          <= data_s1.ac_field;
			data_s2.ac_value          <= data_s1.ac_value;
			data_s2.operand_word      <= data_s1.operand_word;
			data_s2.stack_word        <= data_s1.stack_word;
			data_s2.effective_address <= data_s1.effective_address;
			data_s2.flags_in          <= data_s1.flags_in;
		end
	end

endmodule

// ===== rtl/jss_resolve.sv =====
module jss_resolve import jss_pkg::*; #(
	parameter int GLOBAL_ADDRESS_BITS = 23
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s2,
	input  stp_t      data_s2,
	output logic      ready_s2,
	output logic      valid_s3,
	output out_item_t data_s3,
	input  logic      next_ready
);

	localparam logic [35:0] AMASK = (36'd1 << GLOBAL_ADDRESS_BITS) - 36'd1;

	out_item_t   res;
	logic [12:0] jmask;
	logic [35:0] st;
	logic        adv;

	assign adv      = !valid_s3 || next_ready;
	assign ready_s2 = adv;
	assign st       = data_s2.stepped;
	assign jmask    = {data_s2.ac_field, {JFCL_SHIFT{1'b0}}};

	always_comb begin
		res.take_jump   = 1'b0;
		res.take_skip   = 1'b0;
		res.take_trap   = 1'b0;
		res.ac_write    = 1'b0;
		res.ac_result   = data_s2.ac_value;
		res.mem_write   = 1'b0;
		res.mem_address = 23'd0;
		res.mem_data    = 36'd0;
		res.jump_target = data_s2.effective_address[17:0];
		res.flags_out   = data_s2.flags_in;
		unique case (data_s2.cls)
			CLS_JUMP: res.take_jump = data_s2.cond_hit;
			CLS_SKIP: begin
				res.take_skip = data_s2.cond_hit;
				if (data_s2.ac_field != 4'd0) begin
					res.ac_write  = 1'b1;
					res.ac_result = data_s2.operand_word;
				end
			end
			CLS_AOBJP, CLS_AOBJN: begin
				res.ac_write  = 1'b1;
				res.ac_result = st;
				res.take_jump = (data_s2.cls == CLS_AOBJN) ? st[35] : !st[35];
			end
			CLS_JFCL: begin
				res.take_jump = |(data_s2.flags_in & jmask);
				res.flags_out = data_s2.flags_in & ~jmask;
			end
			CLS_PUSH: begin
				res.ac_write  = 1'b1;
				res.ac_result = st;
				res.mem_write = 1'b1;
				res.mem_data  = data_s2.operand_word;
				if (data_s2.local_ptr) begin
					res.mem_address = {5'd0, st[17:0]};
					if (st[35:18] == 18'd0) begin
						res.flags_out[FLAG_TR2] = 1'b1;
					end
				end else begin
					res.mem_address = st[22:0] & AMASK[22:0];
				end
			end
			CLS_POP, CLS_POPJ: begin
				res.ac_write  = 1'b1;
				res.ac_result = st;
				if (data_s2.local_ptr && (st[35:18] == '1)) begin
					res.flags_out[FLAG_TR2] = 1'b1;
				end
				if (data_s2.cls == CLS_POP) begin
					res.mem_write   = 1'b1;
					res.mem_address = data_s2.effective_address;
					res.mem_data    = data_s2.stack_word;
				end else begin
					res.take_jump   = 1'b1;
					res.jump_target = data_s2.stack_word[17:0];
				end
			end
			CLS_ADJSP: begin
				res.ac_write  = 1'b1;
				res.ac_result = st;
				// sign crossing of a local pointer in the step direction
				if (data_s2.local_ptr && data_s2.step_nz &&
					((data_s2.step_neg && !data_s2.prev_neg && st[35]) ||
					 (!data_s2.step_neg && data_s2.prev_neg && !st[35]))) begin
					res.take_trap           = 1'b1;
					res.flags_out[FLAG_TR2] = 1'b1;
				end
			end
			default: res.take_jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			data_s3 <= res;
		end
	end

endmodule

// ===== rtl/jss_checker.sv =====
module jss_checker import jss_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp_payload
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled result changed");

	// a trap comes only from adjsp, which writes the ac and sets tr2
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.take_trap |->
			rsp_payload.ac_write && rsp_payload.flags_out[FLAG_TR2])
		else $error("trap without ac write or tr2");

	// no memory write leaves address and data clear
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_payload.mem_write |->
			rsp_payload.mem_address == 23'd0 && rsp_payload.mem_data == 36'd0)
		else $error("idle memory fields not clear");

	// skip, jump and trap exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp_payload.take_jump, rsp_payload.take_skip,
			rsp_payload.take_trap}) <= 1)
		else $error("more than one control transfer");

endmodule

bind jump_skip_stack_execute_unit jss_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

// ===== tb/tb_jump_skip_stack_execute_unit.sv =====
`timescale 1ns / 1ps

module tb_jump_skip_stack_execute_unit;
	import jss_pkg::*;

	localparam int GLOBAL_ADDR_BITS = 23;
	localparam int IDLE_LIMIT       = 2000;
	localparam int TAIL_CYCLES      = 12;

	logic clk;
	logic arst_n;

	jss_req_if req ();
	jss_rsp_if rsp ();

	jump_skip_stack_execute_unit #(
		.GLOBAL_ADDRESS_BITS(GLOBAL_ADDR_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	out_item_t pending_results[$];
	int        err_count       = 0;
	int        results_seen    = 0;
	int        stall_cycles    = 0;
	int        rsp_hold_cycles = 0;
	bit        req_gaps_on     = 1'b1;
	bit        rsp_gaps_on     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// instruction predictor

	function automatic logic [35:0] step_halves(input logic [35:0] w, input logic [17:0] d);
		logic [17:0] lh;
		logic [17:0] rh;
		lh = w[35:18] + d;
		rh = w[17:0] + d;
		return {lh, rh};
	endfunction

	function automatic logic ptr_is_local(input logic [35:0] p, input logic sec0);
		return sec0 || p[35] || ((p[29:18] & LOCAL_MASK) == '0);
	endfunction

	// low code bit tests negative, next tests zero, top bit inverts
	function automatic logic cond_met(input logic [2:0] c, input logic [35:0] v);
		return ((c[0] & v[35]) | (c[1] & (v == '0))) ^ c[2];
	endfunction

	function automatic out_item_t execute_instr(input in_item_t it);
		out_item_t   r;
		logic [12:0] flags;
		logic [12:0] jfcl_mask;
		logic [17:0] d;
		logic [35:0] addr_mask;
		r = '0;
		r.ac_result = it.ac_value;
		r.jump_target = it.effective_address[17:0];
		flags = it.flags_in;
		addr_mask = (36'd1 << GLOBAL_ADDR_BITS) - 36'd1;
		if (it.action[8:3] == OP_JUMP[8:3]) begin
			r.take_jump = cond_met(it.action[2:0], it.ac_value);
		end else if (it.action[8:3] == OP_SKIP[8:3]) begin
			if (it.ac_field != '0) begin
				r.ac_write = 1'b1;
				r.ac_result = it.operand_word;
			end
			r.take_skip = cond_met(it.action[2:0], it.operand_word);
		end else begin
			case (it.action)
				OP_AOBJP, OP_AOBJN: begin
					r.ac_result = step_halves(it.ac_value, 18'd1);
					r.ac_write = 1'b1;
					r.take_jump = (it.action == OP_AOBJN) ? r.ac_result[35] : !r.ac_result[35];
				end
				OP_JFCL: begin
					jfcl_mask = {9'd0, it.ac_field} << JFCL_SHIFT;
					r.take_jump = |(flags & jfcl_mask);
					flags = flags & ~jfcl_mask;
				end
				OP_PUSH: begin
					r.ac_write = 1'b1;
					r.mem_write = 1'b1;
					r.mem_data = it.operand_word;
					if (ptr_is_local(it.ac_value, it.in_section_zero)) begin
						r.ac_result = step_halves(it.ac_value, 18'd1);
						if (r.ac_result[35:18] == '0)
							flags[FLAG_TR2] = 1'b1;
						r.mem_address = {5'd0, r.ac_result[17:0]};
					end else begin
						r.ac_result = it.ac_value + 36'd1;
						r.mem_address = 23'(r.ac_result & addr_mask);
					end
				end
				OP_POP, OP_POPJ: begin
					r.ac_write = 1'b1;
					if (ptr_is_local(it.ac_value, it.in_section_zero)) begin
						r.ac_result = step_halves(it.ac_value, '1);
						if (r.ac_result[35:18] == '1)
							flags[FLAG_TR2] = 1'b1;
					end else begin
						r.ac_result = it.ac_value - 36'd1;
					end
					if (it.action == OP_POP) begin
						r.mem_write = 1'b1;
						r.mem_address = it.effective_address;
						r.mem_data = it.stack_word;
					end else begin
						r.take_jump = 1'b1;
						r.jump_target = it.stack_word[17:0];
					end
				end
				OP_ADJSP: begin
					d = it.effective_address[17:0];
					r.ac_write = 1'b1;
					if (ptr_is_local(it.ac_value, it.in_section_zero)) begin
						r.ac_result = step_halves(it.ac_value, d);
						if (d != '0 &&
						    ((d[17] && !it.ac_value[35] && r.ac_result[35]) ||
						     (!d[17] && it.ac_value[35] && !r.ac_result[35]))) begin
							flags[FLAG_TR2] = 1'b1;
							r.take_trap = 1'b1;
						end
					end else begin
						r.ac_result = it.ac_value + {{18{d[17]}}, d};
					end
				end
				default: begin
				end
			endcase
		end
		r.flags_out = flags;
		return r;
	endfunction

	// random values

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [35:0] rand36();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[35:0];
	endfunction

	function automatic logic [17:0] rand_half();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 18'o400000;
			3: return 18'o377777;
			4: return 18'o000001;
			default: return r[17:0];
		endcase
	endfunction

	function automatic logic [35:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {1'b1, 35'd0};
			3: return {rand_half(), rand_half()};
			default: return rand36();
		endcase
	endfunction

	// stack pointers: local, global and the boundaries of both kinds
	function automatic logic [35:0] rand_pointer();
		logic [31:0] r;
		logic [11:0] low12;
		logic [17:0] lh;
		r = $urandom();
		low12 = 12'($urandom_range(1, 4095));
		case (r[1:0])
			2'd0: lh = '1;
			2'd1: lh = '0;
			2'd2: lh = 18'o777776;
			default: lh = 18'o000001;
		endcase
		case ($urandom_range(0, 5))
			0: return rand36();
			1: return {1'b1, r[18:2], rand_half()};
			2: return {rand_half(), rand_half()};
			3: return {1'b0, r[22:18], low12, rand_half()};
			4: return {1'b0, r[22:18], 12'd0, rand_half()};
			default: return {lh, rand_half()};
		endcase
	endfunction

	function automatic logic [22:0] rand_addr();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return r[22:0];
		endcase
	endfunction

	function automatic logic [22:0] rand_step();
		logic [31:0] r;
		logic [17:0] s;
		logic [17:0] d;
		r = $urandom();
		s = 18'($urandom_range(1, 16));
		case ($urandom_range(0, 5))
			0: d = '0;
			1: d = s;
			2: d = -s;
			3: d = 18'o400000;
			4: d = 18'o377777;
			default: d = r[17:0];
		endcase
		return {r[22:18], d};
	endfunction

	function automatic in_item_t rand_instr();
		in_item_t   it;
		logic [2:0] cc;
		int         pick;
		cc = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		it.ac_field = 4'($urandom_range(0, 15));
		it.ac_value = rand_pointer();
		it.operand_word = rand_word();
		it.stack_word = rand_word();
		it.effective_address = rand_addr();
		it.in_section_zero = ($urandom_range(0, 3) == 0);
		it.flags_in = ($urandom_range(0, 9) == 0) ? '1 : 13'($urandom_range(0, 8191));
		if (pick < 14) begin
			it.action = {OP_JUMP[8:3], cc};
			if ($urandom_range(0, 1) == 0)
				it.ac_value = rand_word();
		end else if (pick < 28) begin
			it.action = {OP_SKIP[8:3], cc};
		end else if (pick < 38) begin
			it.action = cc[0] ? OP_AOBJN : OP_AOBJP;
		end else if (pick < 48) begin
			it.action = OP_JFCL;
		end else if (pick < 60) begin
			it.action = OP_PUSH;
		end else if (pick < 72) begin
			it.action = cc[0] ? OP_POPJ : OP_POP;
		end else if (pick < 88) begin
			it.action = OP_ADJSP;
			it.effective_address = rand_step();
		end else begin
			it.action = 9'($urandom_range(0, 511));
		end
		return it;
	endfunction

	function automatic in_item_t pack_instr(input logic [8:0] op, input logic [3:0] acf,
			input logic [35:0] ac, input logic [35:0] mw, input logic [35:0] sw,
			input logic [22:0] ea, input logic sec0, input logic [12:0] flags);
		in_item_t it;
		it.action = op;
		it.ac_field = acf;
		it.ac_value = ac;
		it.operand_word = mw;
		it.stack_word = sw;
		it.effective_address = ea;
		it.in_section_zero = sec0;
		it.flags_in = flags;
		return it;
	endfunction

	// checking

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic compare_field(input string name, input logic [35:0] got,
			input logic [35:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %h, expected %h",
				results_seen, name, got, want));
	endtask

	task automatic check_result(input out_item_t got, input out_item_t want);
		compare_field("take_jump", 36'(got.take_jump), 36'(want.take_jump));
		compare_field("take_skip", 36'(got.take_skip), 36'(want.take_skip));
		compare_field("take_trap", 36'(got.take_trap), 36'(want.take_trap));
		compare_field("ac_write", 36'(got.ac_write), 36'(want.ac_write));
		compare_field("ac_result", got.ac_result, want.ac_result);
		compare_field("mem_write", 36'(got.mem_write), 36'(want.mem_write));
		compare_field("mem_address", 36'(got.mem_address), 36'(want.mem_address));
		compare_field("mem_data", got.mem_data, want.mem_data);
		compare_field("jump_target", 36'(got.jump_target), 36'(want.jump_target));
		compare_field("flags_out", 36'(got.flags_out), 36'(want.flags_out));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0)
				report_error($sformatf("result transaction %0d with none expected",
					results_seen));
			else
				check_result(rsp.payload, pending_results.pop_front());
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_cycles = 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	// result side ready
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				stall_left = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp_gaps_on)
					stall_left = pick_gap();
			end
		end
	end

	// driving

	task automatic send_instr(input in_item_t it);
		int gap;
		gap = req_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.payload <= it;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(execute_instr(it));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// tests

	task automatic test_jump_skip();
		logic [2:0]  cc;
		logic [35:0] probe;
		for (int c = 0; c < 8; c++) begin
			cc = 3'(c);
			case (c % 4)
				0: probe = '0;
				1: probe = {1'b1, 35'd0};
				2: probe = 36'o000000000001;
				default: probe = 36'o377777777777;
			endcase
			send_instr(pack_instr({OP_JUMP[8:3], cc}, 4'($urandom_range(0, 15)), probe,
				'0, '1, c[0] ? '1 : '0, c[1], c[2] ? '1 : '0));
		end
		// skip into ac 0 leaves the ac alone
		send_instr(pack_instr({OP_SKIP[8:3], 3'o1}, '0, '1, {1'b1, 35'd0}, '0, '0, 1'b0, '0));
		send_instr(pack_instr({OP_SKIP[8:3], 3'o3}, '1, '0, '0, '1, '1, 1'b1, '1));
		send_instr(pack_instr({OP_SKIP[8:3], 3'o5}, 4'd7, rand36(), 36'o377777777777, '0,
			'0, 1'b0, '0));
		send_instr(pack_instr({OP_SKIP[8:3], 3'o7}, 4'd1, rand36(), '1, '0, '0, 1'b0, '1));
	endtask

	task automatic test_stack_ops();
		send_instr(pack_instr(OP_AOBJP, 4'd2, '1, '0, '0, 23'o1234, 1'b0, '0));
		send_instr(pack_instr(OP_AOBJN, 4'd3, {18'o777776, 18'o000010}, '0, '0, '0, 1'b1, '0));
		send_instr(pack_instr(OP_JFCL, '1, '0, '0, '0, '1, 1'b0, '1));
		send_instr(pack_instr(OP_JFCL, 4'b0101, '0, '0, '0, '0, 1'b0, '0));
		// push overflow: left half wraps to zero, word still stored
		send_instr(pack_instr(OP_PUSH, 4'd4, {18'o777777, 18'o000100}, '1, '0, '0, 1'b0, '0));
		send_instr(pack_instr(OP_PUSH, 4'd5, {18'o000001, 18'o777777}, 36'o123456654321,
			'0, '0, 1'b0, '0));
		// pop underflow: left half wraps to all ones
		send_instr(pack_instr(OP_POP, 4'd6, {18'o000000, 18'o000005}, '0, '1, '1, 1'b1, '0));
		send_instr(pack_instr(OP_POPJ, 4'd7, {18'o000100, 18'o000000}, '0, 36'o123456654321,
			23'o7654321, 1'b0, '0));
		// adjsp sign crossing downward and upward
		send_instr(pack_instr(OP_ADJSP, 4'd8, {18'o000002, 18'o001000}, '0, '0,
			{5'b10101, 18'o777775}, 1'b1, '0));
		send_instr(pack_instr(OP_ADJSP, 4'd9, {18'o777776, 18'o000010}, '0, '0,
			{5'b00000, 18'o000005}, 1'b0, '0));
		// positive pointer with zero section bits outside section zero is local
		send_instr(pack_instr(OP_ADJSP, 4'd10, {18'o370000, 18'o000100}, '0, '0,
			{5'b01010, 18'o000004}, 1'b0, '1));
		send_instr(pack_instr(OP_ADJSP, 4'd11, {18'o000017, 18'o777777}, '0, '0,
			{5'b11111, 18'o777777}, 1'b0, '0));
		send_instr(pack_instr(9'o777, '1, '1, '1, '1, '1, 1'b1, '1));
	endtask

	task automatic test_random_mix(input int n);
		for (int i = 0; i < n; i++)
			send_instr(rand_instr());
	endtask

	// result side held off long enough for the pipeline to fill and stall input
	task automatic test_output_backpressure(input int n);
		req_gaps_on = 1'b0;
		rsp_hold_cycles = 80;
		for (int i = 0; i < n; i++)
			send_instr(rand_instr());
		req_gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_back_to_back(input int n);
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		for (int i = 0; i < n; i++)
			send_instr(rand_instr());
		wait_drained();
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
	endtask

	task automatic test_drained_groups(input int groups, input int per_group);
		for (int g = 0; g < groups; g++) begin
			for (int i = 0; i < per_group; i++)
				send_instr(rand_instr());
			wait_drained();
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_jump_skip();
		test_stack_ops();
		test_random_mix(300);
		test_output_backpressure(40);
		test_back_to_back(150);
		test_drained_groups(15, 10);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
